// ===== src/skvt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted key-value table package
// Widths, operation codes and sequencer states shared by the table logic.
// ----------------------------------------------------------------------------
package skvt_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int FUNC_W    = 2;
	localparam int KEY_W     = 32;
	localparam int VAL_W     = 32;
	localparam int CNT_OUT_W = 7;

	// key in the low half, value in the high half
	localparam int S_TDATA_W = 64;
	// found, old_value, status, count, zero fill to 48 bits
	localparam int M_TDATA_W = 48;

	localparam logic [FUNC_W-1:0] FN_ADD    = 2'd0;
	localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd1;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;
	localparam logic [FUNC_W-1:0] FN_NONE   = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_SHIFT,
		ST_PUT,
		ST_RESP
	} state_t;

endpackage

// ===== src/sorted_key_value_table.sv =====
// ----------------------------------------------------------------------------
// Sorted key-value table
// Packed ordered array of key/value pairs in one synchronous memory, with
// add/update, search and remove operations.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  tuser: func; tdata: key, value
//  m_*       out        m_tvalid/m_tready  tdata: found, old_value, status, count
//  cfg_*     in         cfg_we             cfg_wdata: order_mode
//
// One transaction at a time. Every request but FN_NONE first scans all held
// entries, then passes a decide state; a remove or insert then moves entries
// one per cycle through the single memory port pair, an insert then adds a
// write state, and the response state loads the result. Reset empties the
// table at once; no clearing pass. A stalled result holds the sequencer in
// its response state; a new request is taken as soon as the result is loaded.
//
module sorted_key_value_table #(
	parameter int CAPACITY = skvt_pkg::CAPACITY_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [skvt_pkg::S_TDATA_W-1:0]  s_tdata,  // [31:0] key, [63:32] value
	input  logic [skvt_pkg::FUNC_W-1:0]     s_tuser,  // [1:0] func
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [skvt_pkg::M_TDATA_W-1:0]  m_tdata,  // [0] found, [32:1] old_value,
	                                                  // [33] status, [40:34] count
	input  logic                            cfg_we,
	input  logic                            cfg_wdata // [0] order_mode
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = skvt_pkg::KEY_W + skvt_pkg::VAL_W;

	skvt_pkg::state_t state_q, state_d;

	logic [EW-1:0] mem_q [CAPACITY];

	logic [skvt_pkg::FUNC_W-1:0] func_q;
	logic [skvt_pkg::KEY_W-1:0]  key_q;
	logic [skvt_pkg::VAL_W-1:0]  value_q;
	logic                        order_q;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               rp_q;
	logic [CW-1:0]               rem_q;
	logic [CW-1:0]               idx_q;
	logic [CW-1:0]               pos_q;
	logic                        pos_set_q;
	logic                        found_q;
	logic                        status_q;
	logic                        dir_up_q;
	logic [skvt_pkg::VAL_W-1:0]  old_q;

	logic                        rd_vld_s1;
	logic [CW-1:0]               rd_idx_s1;
	logic [EW-1:0]               rd_data_s1;

	logic                        out_vld_q;
	logic [skvt_pkg::M_TDATA_W-1:0] out_data_q;

	logic                        issue;
	logic                        we;
	logic [CW-1:0]               waddr_full;
	logic [EW-1:0]               wdata;
	logic                        accept;
	logic                        do_remove;
	logic                        do_insert;
	logic                        full;
	logic [skvt_pkg::KEY_W-1:0]  rd_key;
	logic [skvt_pkg::VAL_W-1:0]  rd_val;
	logic                        key_hit;
	logic                        not_rel;
	logic [CW+skvt_pkg::CNT_OUT_W-1:0] count_ext;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == skvt_pkg::ST_IDLE);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	assign rd_key  = rd_data_s1[skvt_pkg::KEY_W-1:0];
	assign rd_val  = rd_data_s1[EW-1:skvt_pkg::KEY_W];
	assign key_hit = (rd_key == key_q);
	// first entry whose relation to the new key fails marks the insert place
	assign not_rel = order_q ? ($signed(key_q) < $signed(rd_key))
	                         : ($signed(key_q) > $signed(rd_key));

	assign full      = (count_q == CW'(CAPACITY));
	assign do_remove = found_q && (func_q == skvt_pkg::FN_REMOVE);
	assign do_insert = !found_q && (func_q == skvt_pkg::FN_ADD) && !full;
	assign count_ext = {{skvt_pkg::CNT_OUT_W{1'b0}}, count_q};

	always_comb begin
		state_d    = state_q;
		issue      = 1'b0;
		we         = 1'b0;
		waddr_full = '0;
		wdata      = '0;
		case (state_q)
			skvt_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (s_tuser == skvt_pkg::FN_NONE) ? skvt_pkg::ST_RESP
					                                        : skvt_pkg::ST_SCAN;
				end
			end
			skvt_pkg::ST_SCAN: begin
				issue = (rp_q != count_q);
				if (!issue && !rd_vld_s1) begin
					state_d = skvt_pkg::ST_DECIDE;
				end
			end
			skvt_pkg::ST_DECIDE: begin
				state_d = skvt_pkg::ST_RESP;
				if (found_q && func_q == skvt_pkg::FN_ADD) begin
					we         = 1'b1;
					waddr_full = idx_q;
					wdata      = {value_q, key_q};
				end else if (do_remove || do_insert) begin
					state_d = skvt_pkg::ST_SHIFT;
				end
			end
			skvt_pkg::ST_SHIFT: begin
				issue = (rem_q != '0);
				if (rd_vld_s1) begin
					we         = 1'b1;
					waddr_full = dir_up_q ? (rd_idx_s1 + CW'(1)) : (rd_idx_s1 - CW'(1));
					wdata      = rd_data_s1;
				end
				if (!issue && !rd_vld_s1) begin
					state_d = dir_up_q ? skvt_pkg::ST_PUT : skvt_pkg::ST_RESP;
				end
			end
			skvt_pkg::ST_PUT: begin
				we         = 1'b1;
				waddr_full = pos_q;
				wdata      = {value_q, key_q};
				state_d    = skvt_pkg::ST_RESP;
			end
			skvt_pkg::ST_RESP: begin
				if (!out_vld_q || m_tready) begin
					state_d = skvt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = skvt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skvt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// entry memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr_full[AW-1:0]] <= wdata;
		end
		rd_data_s1 <= mem_q[rp_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q   <= 1'b0;
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				order_q <= cfg_wdata;
			end
			rd_vld_s1 <= issue;
			if (state_q == skvt_pkg::ST_DECIDE) begin
				if (do_remove) begin
					count_q <= count_q - CW'(1);
				end else if (do_insert) begin
					count_q <= count_q + CW'(1);
				end
			end
			if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (state_q == skvt_pkg::ST_RESP && (!out_vld_q || m_tready)) begin
				out_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= s_tuser;
			key_q     <= s_tdata[skvt_pkg::KEY_W-1:0];
			value_q   <= s_tdata[skvt_pkg::S_TDATA_W-1:skvt_pkg::KEY_W];
			rp_q      <= '0;
			rem_q     <= '0;
			idx_q     <= '0;
			pos_q     <= count_q;
			pos_set_q <= 1'b0;
			found_q   <= 1'b0;
			status_q  <= 1'b0;
			dir_up_q  <= 1'b0;
			old_q     <= '0;
		end
		if (issue) begin
			rd_idx_s1 <= rp_q;
			if (state_q == skvt_pkg::ST_SHIFT) begin
				rp_q  <= dir_up_q ? (rp_q - CW'(1)) : (rp_q + CW'(1));
				rem_q <= rem_q - CW'(1);
			end else begin
				rp_q <= rp_q + CW'(1);
			end
		end
		if (state_q == skvt_pkg::ST_SCAN && rd_vld_s1) begin
			if (!found_q && key_hit) begin
				found_q <= 1'b1;
				idx_q   <= rd_idx_s1;
				old_q   <= rd_val;
			end
			if (!pos_set_q && not_rel) begin
				pos_set_q <= 1'b1;
				pos_q     <= rd_idx_s1;
			end
		end
		if (state_q == skvt_pkg::ST_DECIDE) begin
			status_q <= !found_q && (func_q == skvt_pkg::FN_ADD) && full;
			if (do_remove) begin
				dir_up_q <= 1'b0;
				rp_q     <= idx_q + CW'(1);
				rem_q    <= count_q - idx_q - CW'(1);
			end else begin
				dir_up_q <= 1'b1;
				rp_q     <= count_q - CW'(1);
				rem_q    <= count_q - pos_q;
			end
		end
		if (state_q == skvt_pkg::ST_RESP && (!out_vld_q || m_tready)) begin
			out_data_q <= {{(skvt_pkg::M_TDATA_W - skvt_pkg::CNT_OUT_W - skvt_pkg::VAL_W - 2)
			               {1'b0}},
			               count_ext[skvt_pkg::CNT_OUT_W-1:0], status_q, old_q, found_q};
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == skvt_pkg::ST_IDLE || state_q == skvt_pkg::ST_RESP) |-> !we)
		else $error("memory write outside an operation");

	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == skvt_pkg::ST_SCAN || state_q == skvt_pkg::ST_RESP))
		else $error("accepted transaction did not start");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == skvt_pkg::ST_RESP))
		else $error("result raised outside response state");

	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[33]))
		else $error("found and full status together");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key-value table testbench
// Drives add, search, remove and no-op requests over the input stream, with random
// bursts, gaps and output stalls. A local copy of the ordered table predicts
// each response, and the response stream is checked field by field.
// ----------------------------------------------------------------------------
module tb;

	localparam int CAPACITY      = skvt_pkg::CAPACITY_DEF;
	localparam int IDLE_LIMIT    = 5000;
	localparam int HOLD_CYCLES   = 600;
	localparam int SETTLE_CYCLES = 8;
	localparam int KEY_POOL_SIZE = 80;
	localparam int MAX_REPORTS   = 40;

	typedef struct packed {
		logic [skvt_pkg::FUNC_W-1:0]       func;
		logic signed [skvt_pkg::KEY_W-1:0] key;
		logic signed [skvt_pkg::VAL_W-1:0] value;
	} request_t;

	typedef struct packed {
		logic                              found;
		logic signed [skvt_pkg::VAL_W-1:0] old_value;
		logic                              status;
		logic [skvt_pkg::CNT_OUT_W-1:0]    count;
	} response_t;

	typedef enum int {
		RX_ALWAYS,
		RX_HALF,
		RX_SPARSE,
		RX_DUTY
	} rx_mode_t;

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [skvt_pkg::S_TDATA_W-1:0]   s_tdata;   // [31:0] key, [63:32] value
	logic [skvt_pkg::FUNC_W-1:0]      s_tuser;   // [1:0] func
	logic                             m_tvalid;
	logic                             m_tready;
	// [0] found, [32:1] old_value, [33] status, [40:34] count
	logic [skvt_pkg::M_TDATA_W-1:0]   m_tdata;
	logic                             cfg_we;
	logic                             cfg_wdata; // [0] order_mode

	// shadow of the table
	logic signed [skvt_pkg::KEY_W-1:0] tbl_keys[CAPACITY];
	logic signed [skvt_pkg::VAL_W-1:0] tbl_values[CAPACITY];
	int                                tbl_count;
	logic                              tbl_order;

	response_t                         expected_q[$];
	logic signed [skvt_pkg::KEY_W-1:0] key_pool[KEY_POOL_SIZE];
	int                                errors;
	int                                idle_cycles;
	int                                burst_left;
	bit                                gaps_on;
	bit                                hold_req;

	sorted_key_value_table #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Table prediction
	// ------------------------------------------------------------------
	function automatic bit goes_before(logic signed [skvt_pkg::KEY_W-1:0] a,
			logic signed [skvt_pkg::KEY_W-1:0] b);
		return tbl_order ? (b <= a) : (a <= b);
	endfunction

	function automatic response_t apply_request(request_t req);
		response_t rsp;
		int        idx;
		int        pos;
		int        i;
		rsp = '0;
		idx = -1;
		if (req.func != skvt_pkg::FN_NONE) begin
			for (i = 0; i < tbl_count; i++)
				if (idx < 0 && tbl_keys[i] == req.key)
					idx = i;
			if (idx >= 0) begin
				rsp.found = 1'b1;
				rsp.old_value = tbl_values[idx];
				if (req.func == skvt_pkg::FN_ADD) begin
					tbl_values[idx] = req.value;
				end else if (req.func == skvt_pkg::FN_REMOVE) begin
					for (i = idx; i + 1 < tbl_count; i++) begin
						tbl_keys[i] = tbl_keys[i + 1];
						tbl_values[i] = tbl_values[i + 1];
					end
					tbl_count--;
				end
			end else if (req.func == skvt_pkg::FN_ADD) begin
				if (tbl_count >= CAPACITY) begin
					rsp.status = 1'b1;
				end else begin
					pos = tbl_count;
					for (i = tbl_count - 1; i >= 0; i--)
						if (!goes_before(req.key, tbl_keys[i]))
							pos = i;
					for (i = tbl_count; i > pos; i--) begin
						tbl_keys[i] = tbl_keys[i - 1];
						tbl_values[i] = tbl_values[i - 1];
					end
					tbl_keys[pos] = req.key;
					tbl_values[pos] = req.value;
					tbl_count++;
				end
			end
		end
		rsp.count = tbl_count[skvt_pkg::CNT_OUT_W-1:0];
		return rsp;
	endfunction

	// ------------------------------------------------------------------
	// Request sender: called at a falling edge, returns at a falling edge
	// ------------------------------------------------------------------
	task automatic send_request(input logic [skvt_pkg::FUNC_W-1:0] func,
			input logic [skvt_pkg::KEY_W-1:0] key, input logic [skvt_pkg::VAL_W-1:0] value);
		request_t req;
		req.func = func;
		req.key = key;
		req.value = value;
		if (burst_left <= 0) begin
			if (gaps_on) begin
				s_tvalid = 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_tvalid = 1'b1;
		s_tdata = {req.value, req.key};
		s_tuser = req.func;
		do @(posedge clk); while (!s_tready);
		expected_q.push_back(apply_request(req));
		burst_left--;
		@(negedge clk);
	endtask

	// stop offering and wait until every response is back
	task automatic wait_drain();
		s_tvalid = 1'b0;
		burst_left = 0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_order(input logic mode);
		wait_drain();
		cfg_we = 1'b1;
		cfg_wdata = mode;
		@(negedge clk);
		cfg_we = 1'b0;
		tbl_order = mode;
	endtask

	function automatic logic [skvt_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [skvt_pkg::KEY_W-1:0] pick_key();
		if ($urandom_range(9) < 8)
			return key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
		return $urandom;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_basic_ops();
		send_request(skvt_pkg::FN_SEARCH, 32'd5, 32'd0);
		send_request(skvt_pkg::FN_REMOVE, 32'd5, 32'd0);
		send_request(skvt_pkg::FN_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(skvt_pkg::FN_ADD, 32'h0, 32'h7FFF_FFFF);
		send_request(skvt_pkg::FN_ADD, 32'h8000_0000, 32'h8000_0000);
		send_request(skvt_pkg::FN_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_request(skvt_pkg::FN_ADD, 32'hFFFF_FFFF, 32'h0);
		send_request(skvt_pkg::FN_ADD, 32'd5, 32'd123);
		send_request(skvt_pkg::FN_ADD, 32'd5, 32'd123);
		send_request(skvt_pkg::FN_SEARCH, 32'hFFFF_FFFF, 32'h1234_5678);
		send_request(skvt_pkg::FN_SEARCH, 32'h0, 32'h0);
		send_request(skvt_pkg::FN_ADD, 32'd5, 32'hDEAD_BEEF);
		send_request(skvt_pkg::FN_REMOVE, 32'h8000_0000, 32'h0);
		send_request(skvt_pkg::FN_REMOVE, 32'h8000_0000, 32'h0);
		send_request(skvt_pkg::FN_SEARCH, 32'h7FFF_FFFF, 32'h0);
		send_request(skvt_pkg::FN_ADD, 32'h5555_5555, 32'hAAAA_AAAA);
		send_request(skvt_pkg::FN_ADD, 32'hAAAA_AAAA, 32'h5555_5555);
		send_request(skvt_pkg::FN_NONE, 32'h5555_5555, 32'h0);
		send_request(skvt_pkg::FN_SEARCH, 32'hAAAA_AAAA, 32'h0);
		send_request(skvt_pkg::FN_REMOVE, 32'hFFFF_FFFF, 32'h0);
		send_request(skvt_pkg::FN_SEARCH, 32'hFFFF_FFFF, 32'h0);
		send_request(skvt_pkg::FN_ADD, 32'h0, 32'h8000_0000);
	endtask

	// fill to capacity, bounce off the full table, then empty it again
	task automatic test_table_full();
		while (tbl_count < CAPACITY)
			send_request(skvt_pkg::FN_ADD, $urandom, pick_value());
		repeat (4) send_request(skvt_pkg::FN_ADD, $urandom, pick_value());
		send_request(skvt_pkg::FN_ADD, tbl_keys[0], pick_value());
		send_request(skvt_pkg::FN_ADD, tbl_keys[CAPACITY - 1], pick_value());
		send_request(skvt_pkg::FN_SEARCH, tbl_keys[$urandom_range(CAPACITY - 1)], $urandom);
		send_request(skvt_pkg::FN_NONE, $urandom, $urandom);
		while (tbl_count > 0) begin
			if ($urandom_range(4) == 0)
				send_request(skvt_pkg::FN_SEARCH, tbl_keys[$urandom_range(tbl_count - 1)],
					$urandom);
			send_request(skvt_pkg::FN_REMOVE, tbl_keys[$urandom_range(tbl_count - 1)],
				$urandom);
		end
	endtask

	task automatic test_random_mix(input int n_items, input int add_pct, input int rem_pct);
		int                            p;
		logic [skvt_pkg::FUNC_W-1:0]   func;
		for (int n = 0; n < n_items; n++) begin
			if (n % 100 == 0)
				gaps_on = $urandom_range(2) != 0;
			p = $urandom_range(99);
			if (p < add_pct)
				func = skvt_pkg::FN_ADD;
			else if (p < add_pct + rem_pct)
				func = skvt_pkg::FN_REMOVE;
			else if (p < 97)
				func = skvt_pkg::FN_SEARCH;
			else
				func = skvt_pkg::FN_NONE;
			send_request(func, pick_key(), pick_value());
		end
		gaps_on = 1'b1;
	endtask

	// hold the response side while requests keep coming
	task automatic test_backpressure();
		gaps_on = 1'b0;
		burst_left = 0;
		hold_req = 1'b1;
		repeat (30) send_request(skvt_pkg::FN_ADD, pick_key(), pick_value());
		s_tvalid = 1'b0;
		while (hold_req)
			@(negedge clk);
		gaps_on = 1'b1;
	endtask

	task automatic test_pause_resume();
		repeat (3) begin
			repeat (15) send_request(skvt_pkg::FUNC_W'($urandom_range(2)), pick_key(),
				pick_value());
			wait_drain();
		end
	endtask

	// ------------------------------------------------------------------
	// Response side
	// ------------------------------------------------------------------
	initial begin : receiver
		int       phase_left;
		rx_mode_t mode;
		phase_left = 0;
		mode = RX_ALWAYS;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			if (phase_left <= 0) begin
				mode = rx_mode_t'($urandom_range(3));
				phase_left = $urandom_range(16, 128);
			end
			phase_left--;
			case (mode)
				RX_ALWAYS: m_tready = 1'b1;
				RX_HALF:   m_tready = 1'($urandom_range(1));
				RX_SPARSE: m_tready = $urandom_range(3) == 0;
				default:   m_tready = (phase_left % 8) < 5;
			endcase
		end
	end

	always @(posedge clk) begin : result_check
		response_t got;
		response_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.found = m_tdata[0];
			got.old_value = m_tdata[32:1];
			got.status = m_tdata[33];
			got.count = m_tdata[40:34];
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected response, expected none, actual %h", $time, got);
			end else begin
				want = expected_q.pop_front();
				if (got.found !== want.found) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: found expected %0d actual %0d", $time, want.found,
							got.found);
				end
				if (got.old_value !== want.old_value) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: old_value expected %0d actual %0d", $time,
							want.old_value, got.old_value);
				end
				if (got.status !== want.status) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: status expected %0d actual %0d", $time, want.status,
							got.status);
				end
				if (got.count !== want.count) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: count expected %0d actual %0d", $time, want.count,
							got.count);
				end
			end
		end
	end

	// count cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		errors = 0;
		idle_cycles = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		hold_req = 1'b0;
		tbl_count = 0;
		tbl_order = 1'b0;
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0;
		key_pool[3] = 32'hFFFF_FFFF;
		key_pool[4] = 32'h1;
		for (int i = 5; i < KEY_POOL_SIZE; i++)
			key_pool[i] = (i % 2) ? $urandom : $urandom_range(200) - 100;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_basic_ops();
		test_table_full();
		write_order(1'b1);
		test_basic_ops();
		test_table_full();
		test_random_mix(380, 65, 20);
		write_order(1'b0);
		test_random_mix(380, 30, 55);
		test_backpressure();
		test_pause_resume();
		write_order(1'b1);
		test_random_mix(330, 55, 30);
		write_order(1'b0);
		test_random_mix(330, 60, 25);

		wait_drain();
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sorted_key_value_table.f =====
src/skvt_pkg.sv
src/sorted_key_value_table.sv
dv/tb.sv
